FILE: rtl/ows_pkg.sv
`default_nettype none

package ows_pkg;

    localparam int MAX_DEVICES = 8;
    localparam int ID_BYTES    = 8;
    localparam int TOTAL_BITS  = ID_BYTES * 8;
    localparam int POS_W       = 7;
    localparam int CNT_W       = $clog2(MAX_DEVICES + 1);
    localparam logic [63:0] ROM_MASK =
        (TOTAL_BITS >= 64) ? {64{1'b1}} : ((64'd1 << TOTAL_BITS) - 64'd1);

    typedef enum logic [1:0] {
        CMD_START    = 2'd0,
        CMD_PRESENCE = 2'd1,
        CMD_BITS     = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_AWAIT = 2'd1,
        PH_BITS  = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_BOTH_ONE    = 3'd1,
        ST_NO_PRESENCE = 3'd2,
        ST_FULL        = 3'd3,
        ST_UNEXPECTED  = 3'd4
    } status_t;

    typedef struct packed {
        logic [63:0]      id_pattern;
        logic [POS_W-1:0] last_fork;
        logic [POS_W-1:0] new_fork;
        logic [POS_W-1:0] bit_position;
        logic [CNT_W-1:0] found_count;
        phase_t           phase;
    } ows_state_t;

    typedef struct packed {
        logic        write_bit;
        logic        pass_done;
        logic [63:0] rom_id;
        logic [2:0]  device_index;
        logic        search_done;
        logic [3:0]  device_count;
        logic [2:0]  status;
    } ows_result_t;

endpackage

`default_nettype wire

FILE: rtl/ows_step.sv
`default_nettype none

module ows_step (
    input  wire ows_pkg::ows_state_t  state,
    input  wire logic [1:0]           cmd,
    input  wire logic                 presence,
    input  wire logic                 bit_true,
    input  wire logic                 bit_complement,
    output ows_pkg::ows_state_t       state_next,
    output ows_pkg::ows_result_t      result
);
    import ows_pkg::*;

    logic [POS_W-1:0] pos;
    logic [63:0]      mask;
    logic [63:0]      id_new;
    logic [POS_W-1:0] fork_new;
    logic             wbit;
    logic [CNT_W-1:0] count_inc;
    logic             pass_end;

    assign pos       = state.bit_position + POS_W'(1);
    assign mask      = 64'd1 << state.bit_position[5:0];
    assign count_inc = state.found_count + CNT_W'(1);
    assign pass_end  = (pos >= POS_W'(TOTAL_BITS));

    // direction choice for one bit pair
    always_comb begin
        id_new   = state.id_pattern;
        fork_new = state.new_fork;
        if (!bit_true && !bit_complement) begin
            if (pos == state.last_fork) begin
                id_new = state.id_pattern | mask;
            end else if (pos > state.last_fork) begin
                id_new   = state.id_pattern & ~mask;
                fork_new = pos;
            end else if ((state.id_pattern & mask) == 64'd0) begin
                fork_new = pos;
            end
        end else if (bit_true) begin
            id_new = state.id_pattern | mask;
        end else begin
            id_new = state.id_pattern & ~mask;
        end
        wbit = |(id_new & mask);
    end

    always_comb begin
        state_next          = state;
        result.write_bit    = 1'b0;
        result.pass_done    = 1'b0;
        result.rom_id       = 64'd0;
        result.device_index = 3'd0;
        result.search_done  = 1'b0;
        result.status       = ST_OK;
        case (cmd)
            CMD_START: begin
                state_next.id_pattern   = 64'd0;
                state_next.last_fork    = '0;
                state_next.new_fork     = '0;
                state_next.bit_position = '0;
                state_next.found_count  = '0;
                state_next.phase        = PH_AWAIT;
            end
            CMD_PRESENCE: begin
                if (state.phase != PH_AWAIT) begin
                    result.status = ST_UNEXPECTED;
                end else if (!presence) begin
                    state_next.found_count = '0;
                    state_next.phase       = PH_IDLE;
                    result.search_done     = 1'b1;
                    result.status          = ST_NO_PRESENCE;
                end else begin
                    state_next.bit_position = '0;
                    state_next.new_fork     = '0;
                    state_next.phase        = PH_BITS;
                end
            end
            CMD_BITS: begin
                if (state.phase != PH_BITS) begin
                    result.status = ST_UNEXPECTED;
                end else if (bit_true && bit_complement) begin
                    state_next.phase   = PH_IDLE;
                    result.search_done = 1'b1;
                    result.status      = ST_BOTH_ONE;
                end else begin
                    state_next.id_pattern   = id_new;
                    state_next.new_fork     = fork_new;
                    state_next.bit_position = pos;
                    result.write_bit        = wbit;
                    if (pass_end) begin
                        state_next.found_count = count_inc;
                        state_next.last_fork   = fork_new;
                        result.pass_done       = 1'b1;
                        result.rom_id          = id_new & ROM_MASK;
                        result.device_index    = state.found_count[2:0];
                        if (fork_new == '0) begin
                            result.search_done = 1'b1;
                            state_next.phase   = PH_IDLE;
                        end else if (count_inc >= CNT_W'(MAX_DEVICES)) begin
                            result.search_done = 1'b1;
                            result.status      = ST_FULL;
                            state_next.phase   = PH_IDLE;
                        end else begin
                            state_next.phase = PH_AWAIT;
                        end
                    end
                end
            end
            default: begin
                result.status = ST_UNEXPECTED;
            end
        endcase
        result.device_count = 4'(state_next.found_count);
    end

endmodule

`default_nettype wire

FILE: rtl/ows_out_reg.sv
`default_nettype none

module ows_out_reg (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 load,
    input  wire ows_pkg::ows_result_t result_in,
    input  wire logic                 m_ready,
    output logic                      m_valid,
    output logic                      can_load,
    output ows_pkg::ows_result_t      result_out
);
    import ows_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    ows_result_t data_reg;

    // a new word may enter when the held one leaves in the same cycle
    assign can_load   = !valid_reg || m_ready;
    assign valid_next = load || (valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= result_in;
        end
    end

    assign m_valid    = valid_reg;
    assign result_out = data_reg;

endmodule

`default_nettype wire

FILE: rtl/onewire_rom_search.sv
// a result word is valid in the cycle after its input word is accepted
// throughput: one word per cycle; a word is taken while the previous result
//   waits, as long as the output register empties in that same cycle
// the single output register and the combinational bit-pair decision set the rate
// reset (aresetn low, synchronous): search state cleared, phase idle, no result held
`default_nettype none

module onewire_rom_search (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_cmd,
    input  wire logic        s_presence,
    input  wire logic        s_bit_true,
    input  wire logic        s_bit_complement,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_write_bit,
    output logic             m_pass_done,
    output logic [63:0]      m_rom_id,
    output logic [2:0]       m_device_index,
    output logic             m_search_done,
    output logic [3:0]       m_device_count,
    output logic [2:0]       m_status
);
    import ows_pkg::*;

    ows_state_t  state_reg;
    ows_state_t  state_next;
    ows_result_t step_result;
    ows_result_t out_result;
    logic        s_fire;

    assign s_fire = s_valid && s_ready;

    ows_step u_step (
        .state          (state_reg),
        .cmd            (s_cmd),
        .presence       (s_presence),
        .bit_true       (s_bit_true),
        .bit_complement (s_bit_complement),
        .state_next     (state_next),
        .result         (step_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.id_pattern   <= 64'd0;
            state_reg.last_fork    <= '0;
            state_reg.new_fork     <= '0;
            state_reg.bit_position <= '0;
            state_reg.found_count  <= '0;
            state_reg.phase        <= PH_IDLE;
        end else if (s_fire) begin
            state_reg <= state_next;
        end
    end

    ows_out_reg u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (s_fire),
        .result_in  (step_result),
        .m_ready    (m_ready),
        .m_valid    (m_valid),
        .can_load   (s_ready),
        .result_out (out_result)
    );

    assign m_write_bit    = out_result.write_bit;
    assign m_pass_done    = out_result.pass_done;
    assign m_rom_id       = out_result.rom_id;
    assign m_device_index = out_result.device_index;
    assign m_search_done  = out_result.search_done;
    assign m_device_count = out_result.device_count;
    assign m_status       = out_result.status;

    // bit position never runs past the id length while pairs are read
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.phase == PH_BITS |-> state_reg.bit_position < POS_W'(TOTAL_BITS))
        else $error("bit position past id length");

    // a start word always leads to the await phase with an empty table
    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_cmd == CMD_START |=>
            state_reg.phase == PH_AWAIT && state_reg.found_count == '0)
        else $error("start did not reset the search");

    // id only reported with a completed pass
    a_rom_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_pass_done |-> m_rom_id == 64'd0)
        else $error("rom id without pass done");

    // a full table ends the search on a completed pass
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_FULL |-> m_pass_done && m_search_done)
        else $error("table full without pass and search done");

    // an ignored word never ends the search
    a_unexp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_UNEXPECTED |-> !m_search_done && !m_pass_done)
        else $error("unexpected word changed search");

endmodule

`default_nettype wire
